/* hw/rtl/g2e_pkg.sv */
// ----------------------------------------------------------------------------
// g2e_pkg - shared constants for the geodetic to ENU converter
// Fixed-point tables (Q60) built at elaboration, pipeline depths, codes.
// ----------------------------------------------------------------------------
package g2e_pkg;

  localparam int CORDIC_STEPS = 32;

  localparam longint Q_ONE     = 64'sh1000_0000_0000_0000;
  localparam longint HALF_Q    = Q_ONE / 2;
  localparam longint THREE_Q   = 3 * Q_ONE;
  localparam longint LAT_LIM   = 64'sd754974720;
  localparam longint LON_LIM   = 64'sd1509949440;
  localparam longint LON_TURN  = 64'sd3019898880;
  localparam longint A_MM_Q16  = 64'sd6378137000 <<< 16;
  localparam longint OUT_LIM   = 64'sd13000000000;

  // configuration register indexes
  localparam logic [1:0] REG_REF_LAT = 2'd0;
  localparam logic [1:0] REG_REF_LON = 2'd1;
  localparam logic [1:0] REG_REF_H   = 2'd2;

  // depth of the earth-centred conversion pipeline, input edge to x/y/z
  localparam int L_ECEF  = CORDIC_STEPS + 45;
  // cycles for the reference pipeline to flush after a register write
  localparam int SETTLE  = L_ECEF + 3;
  localparam int SETTLE_W = $clog2(SETTLE + 1);

  typedef longint atan_arr_t [CORDIC_STEPS];

  function automatic longint mul_q(input longint a, input longint b, input int sh);
    logic signed [127:0] aa;
    logic signed [127:0] bb;
    logic signed [127:0] pp;
    aa = a;
    bb = b;
    pp = aa * bb;
    return pp[sh +: 64];
  endfunction

  // restoring long division, used only while building the tables
  function automatic longint unsigned udiv_c(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint atan_pow2(input int i);
    longint unsigned q;
    longint unsigned d;
    longint s;
    longint t;
    int k;
    int sh;
    q = 64'd1 << 60;
    s = 0;
    k = 0;
    sh = i;
    while (sh <= 60) begin
      d = longint'(2 * k + 1);
      t = longint'(udiv_c(q >> sh, d));
      s = k[0] ? s - t : s + t;
      k = k + 1;
      sh = sh + 2 * i;
    end
    return s;
  endfunction

  function automatic longint atan_third();
    longint unsigned q;
    longint unsigned p;
    longint unsigned d;
    longint s;
    longint t;
    int k;
    q = 64'd1 << 60;
    p = 64'd3;
    s = 0;
    k = 0;
    while (p <= q) begin
      d = longint'(2 * k + 1);
      t = longint'(udiv_c(udiv_c(q, p), d));
      s = k[0] ? s - t : s + t;
      k = k + 1;
      p = p * 64'd9;
    end
    return s;
  endfunction

  function automatic atan_arr_t build_atan();
    atan_arr_t tab;
    tab[0] = atan_pow2(1) + atan_third();
    for (int i = 1; i < CORDIC_STEPS; i++) tab[i] = atan_pow2(i);
    return tab;
  endfunction

  function automatic longint rsqrt_c(input longint v, input longint r0, input int iters);
    longint r;
    r = r0;
    for (int k = 0; k < iters; k++)
      r = mul_q(r, THREE_Q - mul_q(v, mul_q(r, r, 60), 60), 60) >>> 1;
    return r;
  endfunction

  function automatic longint calc_gain();
    longint prod;
    prod = Q_ONE;
    for (int i = 0; i < CORDIC_STEPS; i++)
      if (2 * i <= 62) prod = prod + (prod >>> (2 * i));
    return rsqrt_c(prod, HALF_Q, 8);
  endfunction

  function automatic longint calc_flat();
    longint unsigned r;
    longint unsigned f;
    r = 64'd1000000000;
    f = 64'd0;
    for (int i = 0; i < 60; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= 64'd298257222101) begin
        r = r - 64'd298257222101;
        f = f | 64'd1;
      end
    end
    return longint'(f);
  endfunction

  localparam atan_arr_t ATAN_TAB = build_atan();
  localparam longint PI_Q      = 4 * ATAN_TAB[0];
  localparam longint HALF_PI_Q = PI_Q / 2;
  localparam longint DEG_Q     = PI_Q / 180;
  localparam longint GAIN_K    = calc_gain();
  localparam longint F_Q       = calc_flat();
  localparam longint E2_Q      = 2 * F_Q - mul_q(F_Q, F_Q, 60);
  localparam longint ONE_M_E2  = Q_ONE - E2_Q;

endpackage

/* hw/rtl/g2e_mul.sv */
// ----------------------------------------------------------------------------
// g2e_mul - pipelined 64 x 64 signed multiplier
// Four 32 x 32 partial products in the first stage, sum and sign in the second.
// ----------------------------------------------------------------------------
module g2e_mul (
  input  logic                clk,
  input  logic                en,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic signed [127:0] p
);

  logic [63:0]  ua, ub;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg_r;
  logic [127:0] sum;
  logic signed [127:0] p_r;

  assign ua = a[63] ? 64'(-a) : 64'(a);
  assign ub = b[63] ? 64'(-b) : 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= ua[31:0]  * ub[31:0];
      p01_r <= ua[31:0]  * ub[63:32];
      p10_r <= ua[63:32] * ub[31:0];
      p11_r <= ua[63:32] * ub[63:32];
      neg_r <= a[63] ^ b[63];
    end
  end

  assign sum = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
             + {p11_r, 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? $signed(-sum) : $signed(sum);
    end
  end

  assign p = p_r;

endmodule

/* hw/rtl/g2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// g2e_cordic_cell - one rotation step of the sine/cosine chain
// Rotate by the step angle towards zero residual and register the result.
// ----------------------------------------------------------------------------
module g2e_cordic_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [5:0]         sh,
  input  logic signed [63:0] at,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] z_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic signed [63:0] z_o
);

  logic signed [63:0] dx, dy;
  logic signed [63:0] x_r, y_r, z_r;

  assign dx = y_i >>> sh;
  assign dy = x_i >>> sh;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[63]) begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        z_r <= z_i - at;
      end else begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        z_r <= z_i + at;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

/* hw/rtl/g2e_newton_cell.sv */
// ----------------------------------------------------------------------------
// g2e_newton_cell - one inverse square root refinement step
// r <- r * (3 - v r^2) / 2 over three multiplies; v travels along.
// ----------------------------------------------------------------------------
module g2e_newton_cell (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] v_i,
  input  logic signed [63:0] r_i,
  output logic signed [63:0] v_o,
  output logic signed [63:0] r_o
);

  logic signed [127:0] rr_p, vr_p, nr_p;
  logic signed [63:0]  v_d_r [6];
  logic signed [63:0]  r_d_r [4];
  logic signed [63:0]  t3;

  always_ff @(posedge clk) begin
    if (en) begin
      v_d_r[0] <= v_i;
      r_d_r[0] <= r_i;
      for (int k = 1; k < 6; k++) v_d_r[k] <= v_d_r[k-1];
      for (int k = 1; k < 4; k++) r_d_r[k] <= r_d_r[k-1];
    end
  end

  g2e_mul u_m_rr (.clk(clk), .en(en), .a(r_i), .b(r_i), .p(rr_p));
  g2e_mul u_m_vr (.clk(clk), .en(en), .a(v_d_r[1]), .b(rr_p[123:60]), .p(vr_p));

  assign t3 = g2e_pkg::THREE_Q - vr_p[123:60];

  g2e_mul u_m_nr (.clk(clk), .en(en), .a(r_d_r[3]), .b(t3), .p(nr_p));

  assign r_o = {nr_p[123], nr_p[123:61]};
  assign v_o = v_d_r[5];

endmodule

/* hw/rtl/g2e_ecef.sv */
// ----------------------------------------------------------------------------
// g2e_ecef - geodetic point to earth-centred coordinates
// Clamp/wrap, degrees to radians, CORDIC cell rows, Newton cells for the
// prime-vertical radius, then the x/y/z products.
// ----------------------------------------------------------------------------
module g2e_ecef (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vin,
  input  logic signed [30:0] lat,
  input  logic signed [31:0] lon,
  input  logic signed [24:0] h,
  output logic               vout,
  output logic signed [63:0] slat,
  output logic signed [63:0] clat,
  output logic signed [63:0] slon,
  output logic signed [63:0] clon,
  output logic signed [63:0] x,
  output logic signed [63:0] y,
  output logic signed [63:0] z
);

  localparam int S    = g2e_pkg::CORDIC_STEPS;
  localparam int L    = g2e_pkg::L_ECEF;
  localparam int D_SC = 40;
  localparam int D_H  = S + 43;

  logic               v_r [L];
  logic signed [63:0] lat64, lon64;
  logic signed [63:0] lat_r, lon_r;
  logic signed [24:0] h_d_r [D_H];
  logic signed [127:0] rlat_p, rlon_p;
  logic signed [63:0] zl, zo;
  logic signed [63:0] zl_r, zo_r;
  logic               nl_r, no_r;
  logic               nl_d_r [S];
  logic               no_d_r [S];
  logic signed [63:0] xl [S+1];
  logic signed [63:0] yl [S+1];
  logic signed [63:0] zlc [S+1];
  logic signed [63:0] xo [S+1];
  logic signed [63:0] yo [S+1];
  logic signed [63:0] zoc [S+1];
  logic signed [63:0] slat_r, clat_r, slon_r, clon_r;
  logic signed [63:0] slat_d_r [D_SC];
  logic signed [63:0] clat_d_r [D_SC];
  logic signed [63:0] slon_d_r [D_SC];
  logic signed [63:0] clon_d_r [D_SC];
  logic signed [127:0] sq_p, es_p, nv_p, t_p, nv2_p, x_p, y_p, z_p;
  logic signed [63:0] nv_v [6];
  logic signed [63:0] nv_r [6];
  logic signed [63:0] nv, hs_a, hs_b, hn, zt;

  // clamp latitude, wrap longitude once
  always_comb begin
    lat64 = 64'(lat);
    lon64 = 64'(lon);
    if (lat64 > g2e_pkg::LAT_LIM) lat64 = g2e_pkg::LAT_LIM;
    if (lat64 < -g2e_pkg::LAT_LIM) lat64 = -g2e_pkg::LAT_LIM;
    if (lon64 > g2e_pkg::LON_LIM) lon64 = lon64 - g2e_pkg::LON_TURN;
    if (lon64 < -g2e_pkg::LON_LIM) lon64 = lon64 + g2e_pkg::LON_TURN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vin;
      for (int k = 1; k < L; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat_r <= lat64;
      lon_r <= lon64;
      h_d_r[0] <= h;
      for (int k = 1; k < D_H; k++) h_d_r[k] <= h_d_r[k-1];
    end
  end

  g2e_mul u_m_rlat (.clk(clk), .en(en), .a(lat_r), .b(g2e_pkg::DEG_Q), .p(rlat_p));
  g2e_mul u_m_rlon (.clk(clk), .en(en), .a(lon_r), .b(g2e_pkg::DEG_Q), .p(rlon_p));

  assign zl = rlat_p[86:23];
  assign zo = rlon_p[86:23];

  // fold into [-pi/2, pi/2]; negate the results later
  always_ff @(posedge clk) begin
    if (en) begin
      if (zl > g2e_pkg::HALF_PI_Q) begin
        zl_r <= zl - g2e_pkg::PI_Q; nl_r <= 1'b1;
      end else if (zl < -g2e_pkg::HALF_PI_Q) begin
        zl_r <= zl + g2e_pkg::PI_Q; nl_r <= 1'b1;
      end else begin
        zl_r <= zl; nl_r <= 1'b0;
      end
      if (zo > g2e_pkg::HALF_PI_Q) begin
        zo_r <= zo - g2e_pkg::PI_Q; no_r <= 1'b1;
      end else if (zo < -g2e_pkg::HALF_PI_Q) begin
        zo_r <= zo + g2e_pkg::PI_Q; no_r <= 1'b1;
      end else begin
        zo_r <= zo; no_r <= 1'b0;
      end
      nl_d_r[0] <= nl_r;
      no_d_r[0] <= no_r;
      for (int k = 1; k < S; k++) begin
        nl_d_r[k] <= nl_d_r[k-1];
        no_d_r[k] <= no_d_r[k-1];
      end
    end
  end

  assign xl[0]  = g2e_pkg::GAIN_K;
  assign yl[0]  = 64'sd0;
  assign zlc[0] = zl_r;
  assign xo[0]  = g2e_pkg::GAIN_K;
  assign yo[0]  = 64'sd0;
  assign zoc[0] = zo_r;

  for (genvar k = 0; k < S; k++) begin : g_cordic
    g2e_cordic_cell u_lat (
      .clk(clk), .en(en), .sh(6'(k)), .at(g2e_pkg::ATAN_TAB[k]),
      .x_i(xl[k]), .y_i(yl[k]), .z_i(zlc[k]),
      .x_o(xl[k+1]), .y_o(yl[k+1]), .z_o(zlc[k+1])
    );
    g2e_cordic_cell u_lon (
      .clk(clk), .en(en), .sh(6'(k)), .at(g2e_pkg::ATAN_TAB[k]),
      .x_i(xo[k]), .y_i(yo[k]), .z_i(zoc[k]),
      .x_o(xo[k+1]), .y_o(yo[k+1]), .z_o(zoc[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slat_r <= nl_d_r[S-1] ? -yl[S] : yl[S];
      clat_r <= nl_d_r[S-1] ? -xl[S] : xl[S];
      slon_r <= no_d_r[S-1] ? -yo[S] : yo[S];
      clon_r <= no_d_r[S-1] ? -xo[S] : xo[S];
      slat_d_r[0] <= slat_r;
      clat_d_r[0] <= clat_r;
      slon_d_r[0] <= slon_r;
      clon_d_r[0] <= clon_r;
      for (int k = 1; k < D_SC; k++) begin
        slat_d_r[k] <= slat_d_r[k-1];
        clat_d_r[k] <= clat_d_r[k-1];
        slon_d_r[k] <= slon_d_r[k-1];
        clon_d_r[k] <= clon_d_r[k-1];
      end
    end
  end

  // 1 - e2 sin^2(lat)
  g2e_mul u_m_sq (.clk(clk), .en(en), .a(slat_r), .b(slat_r), .p(sq_p));
  g2e_mul u_m_es (.clk(clk), .en(en), .a(g2e_pkg::E2_Q), .b(sq_p[123:60]), .p(es_p));

  assign nv_v[0] = g2e_pkg::Q_ONE - es_p[123:60];
  assign nv_r[0] = g2e_pkg::Q_ONE;

  for (genvar k = 0; k < 5; k++) begin : g_newton
    g2e_newton_cell u_nc (
      .clk(clk), .en(en), .v_i(nv_v[k]), .r_i(nv_r[k]),
      .v_o(nv_v[k+1]), .r_o(nv_r[k+1])
    );
  end

  g2e_mul u_m_nv (.clk(clk), .en(en), .a(g2e_pkg::A_MM_Q16), .b(nv_r[5]), .p(nv_p));

  assign nv   = nv_p[123:60];
  assign hs_a = 64'(h_d_r[S+40]) <<< 16;
  assign hs_b = 64'(h_d_r[S+42]) <<< 16;
  assign hn   = hs_a + nv;

  g2e_mul u_m_t   (.clk(clk), .en(en), .a(hn), .b(clat_d_r[35]), .p(t_p));
  g2e_mul u_m_nv2 (.clk(clk), .en(en), .a(nv), .b(g2e_pkg::ONE_M_E2), .p(nv2_p));

  assign zt = hs_b + nv2_p[123:60];

  g2e_mul u_m_x (.clk(clk), .en(en), .a(t_p[123:60]), .b(clon_d_r[37]), .p(x_p));
  g2e_mul u_m_y (.clk(clk), .en(en), .a(t_p[123:60]), .b(slon_d_r[37]), .p(y_p));
  g2e_mul u_m_z (.clk(clk), .en(en), .a(zt), .b(slat_d_r[37]), .p(z_p));

  assign vout = v_r[L-1];
  assign slat = slat_d_r[D_SC-1];
  assign clat = clat_d_r[D_SC-1];
  assign slon = slon_d_r[D_SC-1];
  assign clon = clon_d_r[D_SC-1];
  assign x    = x_p[123:60];
  assign y    = y_p[123:60];
  assign z    = z_p[123:60];

endmodule

/* hw/rtl/geodetic_to_local_enu.sv */
// ----------------------------------------------------------------------------
// geodetic_to_local_enu - GRS80 geodetic point to local east/north/up
// Pipelined converter, one point per cycle while not stalled, reference point in registers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : stream of points, tdata = {height, longitude, latitude}.
//   out_* : one result request per point, tdata = {up, north, east}, mm.
//   cfg_* : register writes (index 0 ref latitude, 1 ref longitude,
//           2 ref height); always ready, other indexes are dropped.
// The path from the edge that takes an input request to the edge that raises
//   out_tvalid runs through the two CORDIC cell rows, five Newton cells and the
//   pipelined multipliers strung between them.
// Throughput: one point per cycle, back to back, while results are taken and no flush runs.
// The reference point runs through its own conversion pipeline. After reset
//   and after every register write the input side holds tready low while
//   that pipeline flushes.
// When the receiver stalls, the point pipeline holds; the finished result
//   stays in the output register and the input side stops taking requests
//   until the result is taken.
// Reset clears all valid flags and the output register's valid.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // latitude[30:0], longitude[62:31], height[87:63]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // east[34:0], north[69:35], up[104:70], zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic                         en;
  logic [g2e_pkg::SETTLE_W-1:0] settle_r;
  logic signed [30:0]           ref_lat_r;
  logic signed [31:0]           ref_lon_r;
  logic signed [24:0]           ref_h_r;

  logic               pv;
  logic signed [63:0] p_slat, p_clat, p_slon, p_clon, p_x, p_y, p_z;
  logic signed [63:0] r_slat, r_clat, r_slon, r_clon, r_x, r_y, r_z;
  logic signed [127:0] rsc_p, rss_p, rcc_p, rcs_p;

  logic               v1_r, v2_r, v3_r;
  logic signed [63:0] dx_r, dy_r, dz_r;
  logic signed [127:0] e1_p, e2_p, n1_p, n2_p, n3_p, u1_p, u2_p, u3_p;
  logic signed [63:0] e_sum, n_sum, u_sum;
  logic               out_tvalid_r;
  logic signed [34:0] east_r, north_r, up_r;

  function automatic logic signed [34:0] finish(input logic signed [63:0] v);
    logic signed [63:0] mm;
    mm = (v + 64'sd32768) >>> 16;
    if (mm > g2e_pkg::OUT_LIM) mm = g2e_pkg::OUT_LIM;
    if (mm < -g2e_pkg::OUT_LIM) mm = -g2e_pkg::OUT_LIM;
    return mm[34:0];
  endfunction

  // advance the pipeline unless the result register is stuck
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en && (settle_r == '0);
  assign cfg_ready = 1'b1;

  // reference registers and flush counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      ref_h_r   <= '0;
      settle_r  <= g2e_pkg::SETTLE_W'(g2e_pkg::SETTLE);
    end else if (cfg_valid) begin
      case (cfg_index)
        g2e_pkg::REG_REF_LAT: ref_lat_r <= cfg_data[30:0];
        g2e_pkg::REG_REF_LON: ref_lon_r <= cfg_data;
        g2e_pkg::REG_REF_H:   ref_h_r   <= cfg_data[24:0];
        default: ;
      endcase
      settle_r <= g2e_pkg::SETTLE_W'(g2e_pkg::SETTLE);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // point path: holds with the rest of the pipeline
  g2e_ecef u_pt (
    .clk(clk), .rst_n(rst_n), .en(en), .vin(in_tvalid && in_tready),
    .lat(in_tdata[30:0]), .lon(in_tdata[62:31]), .h(in_tdata[87:63]),
    .vout(pv), .slat(p_slat), .clat(p_clat), .slon(p_slon), .clon(p_clon),
    .x(p_x), .y(p_y), .z(p_z)
  );

  // reference path: free running on the registers
  g2e_ecef u_rf (
    .clk(clk), .rst_n(rst_n), .en(1'b1), .vin(1'b0),
    .lat(ref_lat_r), .lon(ref_lon_r), .h(ref_h_r),
    .vout(), .slat(r_slat), .clat(r_clat), .slon(r_slon), .clon(r_clon),
    .x(r_x), .y(r_y), .z(r_z)
  );

  // rotation terms of the reference
  g2e_mul u_m_rsc (.clk(clk), .en(1'b1), .a(r_slat), .b(r_clon), .p(rsc_p));
  g2e_mul u_m_rss (.clk(clk), .en(1'b1), .a(r_slat), .b(r_slon), .p(rss_p));
  g2e_mul u_m_rcc (.clk(clk), .en(1'b1), .a(r_clat), .b(r_clon), .p(rcc_p));
  g2e_mul u_m_rcs (.clk(clk), .en(1'b1), .a(r_clat), .b(r_slon), .p(rcs_p));

  // difference from the reference
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= p_x - r_x;
      dy_r <= p_y - r_y;
      dz_r <= p_z - r_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= pv;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  g2e_mul u_m_e1 (.clk(clk), .en(en), .a(dx_r), .b(r_slon), .p(e1_p));
  g2e_mul u_m_e2 (.clk(clk), .en(en), .a(dy_r), .b(r_clon), .p(e2_p));
  g2e_mul u_m_n1 (.clk(clk), .en(en), .a(dx_r), .b(rsc_p[123:60]), .p(n1_p));
  g2e_mul u_m_n2 (.clk(clk), .en(en), .a(dy_r), .b(rss_p[123:60]), .p(n2_p));
  g2e_mul u_m_n3 (.clk(clk), .en(en), .a(dz_r), .b(r_clat), .p(n3_p));
  g2e_mul u_m_u1 (.clk(clk), .en(en), .a(dx_r), .b(rcc_p[123:60]), .p(u1_p));
  g2e_mul u_m_u2 (.clk(clk), .en(en), .a(dy_r), .b(rcs_p[123:60]), .p(u2_p));
  g2e_mul u_m_u3 (.clk(clk), .en(en), .a(dz_r), .b(r_slat), .p(u3_p));

  assign e_sum = e2_p[123:60] - e1_p[123:60];
  assign n_sum = n3_p[123:60] - n1_p[123:60] - n2_p[123:60];
  assign u_sum = u1_p[123:60] + u2_p[123:60] + u3_p[123:60];

  // round, saturate and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      east_r  <= finish(e_sum);
      north_r <= finish(n_sum);
      up_r    <= finish(u_sum);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, up_r, north_r, east_r};

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> !in_tready)
    else $error("input taken right after a register write");

  a_east_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (64'(east_r) <= g2e_pkg::OUT_LIM && 64'(east_r) >= -g2e_pkg::OUT_LIM))
    else $error("east beyond saturation bound");

  a_up_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (64'(up_r) <= g2e_pkg::OUT_LIM && 64'(up_r) >= -g2e_pkg::OUT_LIM))
    else $error("up beyond saturation bound");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline stalled");

endmodule

/* sim/geodetic_to_local_enu_tb.sv */
// ----------------------------------------------------------------------------
// geodetic_to_local_enu_tb - self-checking bench for the geodetic to ENU block
// Drives points and reference settings and holds a fixed-point model of the
// GRS80 conversion and tangent-frame rotation. Each result is compared field
// by field with the oldest prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu_tb;

  localparam int  LATENCY   = g2e_pkg::CORDIC_STEPS + 49;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int  N_RANDOM  = 1000;
  // an index with no register behind it
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic signed [24:0] height;
    logic signed [31:0] longitude;
    logic signed [30:0] latitude;
  } point_t;

  typedef struct packed {
    logic signed [34:0] up;
    logic signed [34:0] north;
    logic signed [34:0] east;
  } enu_t;

  // directed row: point, and a typed expectation where it is obvious
  typedef struct {
    point_t pt;
    bit     known;
    enu_t   res;
  } stim_row_t;

  typedef struct {
    longint slat, clat, slon, clon, x, y, z;
  } ecef_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // reference point as the block should hold it
  longint ref_lat_m, ref_lon_m, ref_h_m;
  enu_t   enu_pending[$];
  int     errors = 0;
  int     send_idle = 14, recv_idle = 64;
  longint cycles = 0;

  geodetic_to_local_enu dut (.*);

  always #4 clk = ~clk;

  // ---- fixed-point predictor ----------------------------------------------
  function automatic longint fmul(longint a, longint b, int sh);
    logic signed [127:0] p;
    p = 128'(signed'(a)) * 128'(signed'(b));
    return longint'(p >>> sh);
  endfunction

  function automatic longint inv_root(longint v, longint r, int n);
    for (int k = 0; k < n; k++)
      r = fmul(r, g2e_pkg::THREE_Q - fmul(v, fmul(r, r, 60), 60), 60) >>> 1;
    return r;
  endfunction

  task automatic rotate_angle(input longint th, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = g2e_pkg::GAIN_K; y = 0; z = th; flip = 0;
    // fold into the right half-plane, negate afterwards
    if (z > g2e_pkg::HALF_PI_Q) begin z -= g2e_pkg::PI_Q; flip = 1; end
    else if (z < -g2e_pkg::HALF_PI_Q) begin z += g2e_pkg::PI_Q; flip = 1; end
    for (int i = 0; i < g2e_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= g2e_pkg::ATAN_TAB[i]; end
      else begin x += dx; y -= dy; z += g2e_pkg::ATAN_TAB[i]; end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic geo_to_ecef(input longint lat, input longint lon, input longint h,
                             output ecef_t p);
    longint w, nv, hs, t;
    // clamp latitude, wrap longitude once
    if (lat > g2e_pkg::LAT_LIM) lat = g2e_pkg::LAT_LIM;
    if (lat < -g2e_pkg::LAT_LIM) lat = -g2e_pkg::LAT_LIM;
    if (lon > g2e_pkg::LON_LIM) lon -= g2e_pkg::LON_TURN;
    if (lon < -g2e_pkg::LON_LIM) lon += g2e_pkg::LON_TURN;
    rotate_angle(fmul(lat, g2e_pkg::DEG_Q, 23), p.slat, p.clat);
    rotate_angle(fmul(lon, g2e_pkg::DEG_Q, 23), p.slon, p.clon);
    w  = g2e_pkg::Q_ONE - fmul(g2e_pkg::E2_Q, fmul(p.slat, p.slat, 60), 60);
    nv = fmul(g2e_pkg::A_MM_Q16, inv_root(w, g2e_pkg::Q_ONE, 5), 60);
    hs = h * 65536;
    t  = fmul(hs + nv, p.clat, 60);
    p.x = fmul(t, p.clon, 60);
    p.y = fmul(t, p.slon, 60);
    p.z = fmul(hs + fmul(nv, g2e_pkg::ONE_M_E2, 60), p.slat, 60);
  endtask

  function automatic logic [34:0] to_mm(longint v);
    longint mm;
    mm = (v + 32768) >>> 16;
    if (mm > g2e_pkg::OUT_LIM) mm = g2e_pkg::OUT_LIM;
    if (mm < -g2e_pkg::OUT_LIM) mm = -g2e_pkg::OUT_LIM;
    return mm[34:0];
  endfunction

  task automatic predict_enu(input point_t pt, output enu_t r);
    ecef_t a, b;
    longint dx, dy, dz, e, n, u;
    geo_to_ecef(longint'(pt.latitude), longint'(pt.longitude), longint'(pt.height), a);
    geo_to_ecef(ref_lat_m, ref_lon_m, ref_h_m, b);
    dx = a.x - b.x; dy = a.y - b.y; dz = a.z - b.z;
    e = -fmul(dx, b.slon, 60) + fmul(dy, b.clon, 60);
    n = -fmul(dx, fmul(b.slat, b.clon, 60), 60) - fmul(dy, fmul(b.slat, b.slon, 60), 60)
        + fmul(dz, b.clat, 60);
    u = fmul(dx, fmul(b.clat, b.clon, 60), 60) + fmul(dy, fmul(b.clat, b.slon, 60), 60)
        + fmul(dz, b.slat, 60);
    r.east = to_mm(e); r.north = to_mm(n); r.up = to_mm(u);
  endtask

  // ---- result checking ------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Mismatches found");
      $finish;
    end
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle);
    if (rst_n && out_tvalid && out_tready) begin
      enu_t got, want;
      got = out_tdata[104:0];
      if (enu_pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = enu_pending.pop_front();
        if (got.east !== want.east) begin
          $display("%0t east exp %0d got %0d", $time, want.east, got.east); errors++;
        end
        if (got.north !== want.north) begin
          $display("%0t north exp %0d got %0d", $time, want.north, got.north); errors++;
        end
        if (got.up !== want.up) begin
          $display("%0t up exp %0d got %0d", $time, want.up, got.up); errors++;
        end
      end
    end
  end

  // ---- stimulus ----------------------------------------------------------------
  // write one register; an index with no register is dropped by the block
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      g2e_pkg::REG_REF_LAT: ref_lat_m = longint'(signed'(val[30:0]));
      g2e_pkg::REG_REF_LON: ref_lon_m = longint'(signed'(val[31:0]));
      g2e_pkg::REG_REF_H:   ref_h_m   = longint'(signed'(val[24:0]));
      default: ;
    endcase
  endtask

  // drain: drop valid, wait for every prediction, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (enu_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // valid stays high after the request is taken; idling or drain drops it
  task automatic send_point(input point_t pt, input bit known, input enu_t typed);
    enu_t r;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_enu(pt, r);
    if (known && r !== typed) begin
      $display("%0t table row exp %h model %h", $time, typed, r);
      errors++;
    end
    in_tvalid <= 1'b1; in_tdata <= pt;
    enu_pending.push_back(r);
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic point_t rand_point();
    point_t p;
    p.latitude  = 31'($urandom_range(2 * 754974720) - 754974720);
    p.longitude = 32'(longint'($urandom_range(32'd3019898880)) - 1509949440);
    p.height    = 25'($urandom_range(10100000) - 100000);
    case ($urandom_range(9))
      0: p.latitude  = 31'($urandom);   // beyond the poles, clamped
      1: p.longitude = $urandom;        // beyond the antimeridian, wrapped
      2: p.height    = 25'($urandom);   // any 25-bit height
      default: ;
    endcase
    return p;
  endfunction

  stim_row_t rows[$];

  initial begin
    stim_row_t row;
    point_t p;
    // extremes and special cases; origin against zero reference is exact
    row.known = 1; row.res = '0; row.pt = '0; rows.push_back(row);
    row.known = 0;
    p = '0; p.latitude = 31'sd754974720;   row.pt = p; rows.push_back(row);
    p = '0; p.latitude = -31'sd754974720;  row.pt = p; rows.push_back(row);
    p = '0; p.latitude = 31'h3fff_ffff;    row.pt = p; rows.push_back(row);
    p = '0; p.latitude = 31'h4000_0000;    row.pt = p; rows.push_back(row);
    p = '0; p.longitude = 32'sd1509949440;  row.pt = p; rows.push_back(row);
    p = '0; p.longitude = -32'sd1509949440; row.pt = p; rows.push_back(row);
    p = '0; p.longitude = 32'h7fff_ffff;   row.pt = p; rows.push_back(row);
    p = '0; p.longitude = 32'h8000_0000;   row.pt = p; rows.push_back(row);
    p = '0; p.longitude = 32'hffff_ffff;   row.pt = p; rows.push_back(row);
    p = '0; p.height = 25'sd10000000;      row.pt = p; rows.push_back(row);
    p = '0; p.height = -25'sd100000;       row.pt = p; rows.push_back(row);
    p = '0; p.height = 25'h0ff_ffff;       row.pt = p; rows.push_back(row);
    p = '0; p.height = 25'h100_0000;       row.pt = p; rows.push_back(row);
    p.latitude = 31'sd754974720; p.longitude = 32'sd754974720;
    p.height = 25'sd10000000;              row.pt = p; rows.push_back(row);
    p.latitude = -31'sd377487360; p.longitude = -32'sd1509949440;
    p.height = -25'sd100000;               row.pt = p; rows.push_back(row);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    ref_lat_m = 0; ref_lon_m = 0; ref_h_m = 0;

    foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].res);
    drain();

    // far reference at the south pole, then random points against it
    write_reg(g2e_pkg::REG_REF_LAT, -32'sd754974720);
    write_reg(g2e_pkg::REG_REF_LON, 32'sd1509949440);
    write_reg(g2e_pkg::REG_REF_H, 32'sd10000000);
    write_reg(REG_NONE, $urandom);
    for (int i = 0; i < 6; i++) send_point(rand_point(), 0, '0);
    drain();

    // random phases with different idling and reference settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 14 : (ph == 1) ? 64 : 0;
      recv_idle = (ph == 0) ? 64 : (ph == 1) ? 14 : 0;
      write_reg(g2e_pkg::REG_REF_LAT, (ph == 2) ? 32'sd754974720 : $urandom);
      write_reg(g2e_pkg::REG_REF_LON, (ph == 2) ? -32'sd1509949440 : $urandom);
      write_reg(g2e_pkg::REG_REF_H, (ph == 2) ? -32'sd100000 : $urandom);
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        send_point(rand_point(), 0, '0);
        // hold the sender until the pipeline empties, once per phase
        if (i == 50) begin
          in_tvalid <= 1'b0;
          while (enu_pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/g2e_pkg.sv
hw/rtl/g2e_mul.sv
hw/rtl/g2e_cordic_cell.sv
hw/rtl/g2e_newton_cell.sv
hw/rtl/g2e_ecef.sv
hw/rtl/geodetic_to_local_enu.sv
sim/geodetic_to_local_enu_tb.sv
